### hw/rtl/bitplane_transpose_sign_fold_defines.svh
// ----------------------------------------------------------------------------
// Bit-plane transpose assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef BITPLANE_TRANSPOSE_SIGN_FOLD_DEFINES_SVH
`define BITPLANE_TRANSPOSE_SIGN_FOLD_DEFINES_SVH

// The condition holds at every clock edge out of reset.
`define BTS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the trigger holds, the consequence holds in the next cycle.
`define BTS_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bts_pkg.sv
// ----------------------------------------------------------------------------
// Bit-plane transpose package
// Shared types, register indexes and the sign fold helpers.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int GROUP_SIZE = 16;

  typedef logic [15:0] word_t;
  typedef logic [3:0]  pos_t;
  typedef logic [4:0]  cnt_t;
  typedef word_t [GROUP_SIZE-1:0] group_words_t;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  localparam logic CFG_DIRECTION    = 1'b0;
  localparam logic CFG_FINAL_PIXELS = 1'b1;

  localparam cnt_t FULL_GROUP = 5'd16;

  typedef struct packed {
    dir_t direction;
    cnt_t final_pixels;
  } cfg_t;

  typedef struct packed {
    cnt_t count;   // words actually received, 1..16
    dir_t dir;
    logic last;
    cnt_t n;       // results to emit, 1..16
  } group_meta_t;

  typedef struct packed {
    logic  en;
    pos_t  addr;
    word_t data;
  } wr_req_t;

  typedef struct packed {
    logic        en;
    group_meta_t meta;
  } close_req_t;

  typedef struct packed {
    logic        wr_full;
    logic        rd_valid;
    group_meta_t rd_meta;
  } q_status_t;

  typedef struct packed {
    pos_t fill;
  } front_status_t;

  typedef struct packed {
    logic emit;
    logic done;
  } back_status_t;

  typedef struct packed {
    word_t word;
    pos_t  index;
    logic  last;
  } result_t;

  // Two's complement to sign-magnitude with the sign in bit 0.
  function automatic word_t fold_pixel(word_t x);
    word_t mag;
    mag = word_t'(16'd0 - x);
    if (x[15]) begin
      return {mag[14:0], 1'b1};
    end
    return {x[14:0], 1'b0};
  endfunction

  // A negative sign with zero magnitude stands for the most negative pixel.
  function automatic word_t unfold_pixel(logic sign, logic [14:0] mag);
    if (!sign) begin
      return {1'b0, mag};
    end
    if (mag == 15'd0) begin
      return 16'h8000;
    end
    return word_t'(16'd0 - {1'b0, mag});
  endfunction

  function automatic cnt_t clamp_pixels(cnt_t v);
    if (v == 5'd0) begin
      return 5'd1;
    end
    if (v > FULL_GROUP) begin
      return FULL_GROUP;
    end
    return v;
  endfunction

endpackage

### hw/rtl/bts_front.sv
// ----------------------------------------------------------------------------
// Bit-plane transpose front end
// Accepts words, tracks the fill position and closes groups.
// ----------------------------------------------------------------------------
module bts_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [15:0]            in_word,
  input  logic                   in_last,
  input  bts_pkg::cfg_t          cfg,
  input  bts_pkg::q_status_t     q_st,
  output bts_pkg::wr_req_t       wr,
  output bts_pkg::close_req_t    close,
  output bts_pkg::front_status_t st
);
  import bts_pkg::*;

  pos_t fill;
  logic accept;
  logic closing;

  assign accept  = push && !q_st.wr_full;
  assign closing = accept && (fill == pos_t'(GROUP_SIZE - 1) || in_last);

  always_comb begin
    wr.en            = accept;
    wr.addr          = fill;
    wr.data          = in_word;
    close.en         = closing;
    close.meta.count = {1'b0, fill} + 5'd1;
    close.meta.dir   = cfg.direction;
    close.meta.last  = in_last;
    if (cfg.direction == DIR_DECODE && in_last) begin
      close.meta.n = clamp_pixels(cfg.final_pixels);
    end else begin
      close.meta.n = FULL_GROUP;
    end
    st.fill = fill;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (closing) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill + 4'd1;
    end
  end

endmodule

### hw/rtl/bts_group_queue.sv
// ----------------------------------------------------------------------------
// Bit-plane transpose group queue
// Two group buffers in ping-pong order between the front and the back end.
// ----------------------------------------------------------------------------
module bts_group_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  bts_pkg::wr_req_t      wr,
  input  bts_pkg::close_req_t   close,
  input  logic                  rd_done,
  output bts_pkg::q_status_t    st,
  output bts_pkg::group_words_t rd_words
);
  import bts_pkg::*;

  word_t       words [2][GROUP_SIZE];
  group_meta_t meta  [2];
  logic [1:0]  slot_valid;
  logic [1:0]  slot_valid_next;
  logic        wr_ptr;
  logic        rd_ptr;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      words[wr_ptr][wr.addr] <= wr.data;
    end
    if (close.en) begin
      meta[wr_ptr] <= close.meta;
    end
  end

  // A slot is filled only when free and drained only when full, so a close
  // and a drain in the same cycle always touch different slots.
  always_comb begin
    slot_valid_next = slot_valid;
    if (close.en) begin
      slot_valid_next[wr_ptr] = 1'b1;
    end
    if (rd_done) begin
      slot_valid_next[rd_ptr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
    end else begin
      slot_valid <= slot_valid_next;
      if (close.en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_done) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_comb begin
    st.wr_full  = slot_valid[wr_ptr];
    st.rd_valid = slot_valid[rd_ptr];
    st.rd_meta  = meta[rd_ptr];
    for (int p = 0; p < GROUP_SIZE; p++) begin
      rd_words[p] = words[rd_ptr][p];
    end
  end

endmodule

### hw/rtl/bts_back.sv
// ----------------------------------------------------------------------------
// Bit-plane transpose back end
// Emits one head group plane or pixel per cycle while its result queue has room.
// ----------------------------------------------------------------------------
module bts_back (
  input  logic                  clk,
  input  logic                  rst,
  input  bts_pkg::q_status_t    q_st,
  input  bts_pkg::group_words_t rd_words,
  input  logic                  pop,
  output bts_pkg::back_status_t st,
  output logic                  empty,
  output logic [15:0]           out_word,
  output logic [3:0]            out_index,
  output logic                  out_last
);
  import bts_pkg::*;

  pos_t         idx;
  group_words_t w;
  group_words_t folded;
  word_t        plane;
  logic [14:0]  mag;
  result_t      res;
  logic         emit;
  logic         done;

  result_t      ent [2];
  logic         ent_wptr;
  logic         ent_rptr;
  logic [1:0]   ent_count;
  logic         popped;

  // Words past the received count read as zero (short final group).
  always_comb begin
    for (int p = 0; p < GROUP_SIZE; p++) begin
      if (5'(p) < q_st.rd_meta.count) begin
        w[p] = rd_words[p];
      end else begin
        w[p] = '0;
      end
    end
    for (int p = 0; p < GROUP_SIZE; p++) begin
      folded[p] = fold_pixel(w[p]);
      plane[p]  = folded[p][idx];
    end
    for (int b = 1; b < GROUP_SIZE; b++) begin
      mag[b-1] = w[b][idx];
    end
    res.index = idx;
    res.last  = q_st.rd_meta.last && ({1'b0, idx} == q_st.rd_meta.n - 5'd1);
    unique case (q_st.rd_meta.dir)
      DIR_ENCODE: res.word = plane;
      DIR_DECODE: res.word = unfold_pixel(w[0][idx], mag);
      default:    res.word = plane;
    endcase
  end

  assign emit    = q_st.rd_valid && (ent_count != 2'd2);
  assign done    = emit && ({1'b0, idx} == q_st.rd_meta.n - 5'd1);
  assign st.emit = emit;
  assign st.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (done) begin
      idx <= '0;
    end else if (emit) begin
      idx <= idx + 4'd1;
    end
  end

  assign popped = pop && (ent_count != 2'd0);

  always_ff @(posedge clk) begin
    if (emit) begin
      ent[ent_wptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_wptr  <= 1'b0;
      ent_rptr  <= 1'b0;
      ent_count <= '0;
    end else begin
      if (emit) begin
        ent_wptr <= ~ent_wptr;
      end
      if (popped) begin
        ent_rptr <= ~ent_rptr;
      end
      ent_count <= ent_count + 2'(emit) - 2'(popped);
    end
  end

  assign empty     = (ent_count == 2'd0);
  assign out_word  = ent[ent_rptr].word;
  assign out_index = ent[ent_rptr].index;
  assign out_last  = ent[ent_rptr].last;

endmodule

### hw/rtl/bitplane_transpose_sign_fold.sv
// ----------------------------------------------------------------------------
// Bit-plane transpose with sign folding
// 16x16 bit-plane transpose of signed pixels, encode and decode directions.
// ----------------------------------------------------------------------------
// The input side is a queue: a transaction completes when push is high and
// full is low. Each transaction carries one pixel (encode) or one plane word
// (decode); in_last marks the final word of the stream and closes the group.
// The result side is a queue too: while empty is low the oldest result is on
// out_word, out_index and out_last, and it is taken when pop is high.
// Configuration is written through cfg_wen, cfg_addr and cfg_data while the
// block is idle; index 0 is the direction and index 1 the pixel count of the
// final decoded group.
// A group closes on its 16th word or on in_last. When the back end is idle,
// the closing transaction marks the group's buffer valid, and its first
// result is then registered into the result queue and shown on the ports;
// further results follow one per cycle while the result queue has room. Two
// group buffers alternate, so one group fills while the previous one drains,
// and input and output both sustain one transaction per cycle; the rate is
// set by the single result per cycle that the back end produces. A short
// final encode group still yields 16 planes, so input can wait there.
// Reset restores the register defaults and empties both group buffers and the
// result queue. When the receiver stops popping, the two-entry result queue
// fills, the back end holds, and once both group buffers are full, full rises.
// ----------------------------------------------------------------------------
module bitplane_transpose_sign_fold (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_word,
  input  logic        in_last,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_word,
  output logic [3:0]  out_index,
  output logic        out_last,
  input  logic        cfg_wen,
  input  logic        cfg_addr,
  input  logic [4:0]  cfg_data
);
  import bts_pkg::*;

  `include "bitplane_transpose_sign_fold_defines.svh"

  cfg_t          cfg;
  wr_req_t       wr;
  close_req_t    close;
  q_status_t     q_st;
  front_status_t f_st;
  back_status_t  b_st;
  group_words_t  rd_words;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction    <= DIR_ENCODE;
      cfg.final_pixels <= FULL_GROUP;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        CFG_DIRECTION:    cfg.direction    <= dir_t'(cfg_data[0]);
        CFG_FINAL_PIXELS: cfg.final_pixels <= cfg_data;
        default:          cfg.direction    <= cfg.direction;
      endcase
    end
  end

  // The front end writes words into the free group buffer and closes groups.
  bts_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .in_word (in_word),
    .in_last (in_last),
    .cfg     (cfg),
    .q_st    (q_st),
    .wr      (wr),
    .close   (close),
    .st      (f_st)
  );

  // The queue holds up to two closed or filling groups.
  bts_group_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .close    (close),
    .rd_done  (b_st.done),
    .st       (q_st),
    .rd_words (rd_words)
  );

  // The back end turns the head group into planes or pixels.
  bts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_st      (q_st),
    .rd_words  (rd_words),
    .pop       (pop),
    .st        (b_st),
    .empty     (empty),
    .out_word  (out_word),
    .out_index (out_index),
    .out_last  (out_last)
  );

  assign full = q_st.wr_full;

  // A group is only closed into a free buffer.
  `BTS_ASSERT_ALWAYS(a_close_into_free, !close.en || !q_st.wr_full, "close into full buffer")
  // The back end only produces results from a closed group.
  `BTS_ASSERT_ALWAYS(a_emit_needs_group, !b_st.emit || q_st.rd_valid, "emit without a group")
  // After a transaction that closes a group, the fill position restarts.
  `BTS_ASSERT_NEXT(a_fill_restart, close.en, f_st.fill == 4'd0, "fill not reset after close")

endmodule

### test/bitplane_checker.sv
// ----------------------------------------------------------------------------
// Bit-plane transpose checker
// Watches the input, result and register ports of the transpose block, keeps
// its own copy of the group buffer and settings, predicts every plane word or
// pixel, and compares each popped result against the oldest prediction.
// ----------------------------------------------------------------------------
module bitplane_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [15:0] in_word,
  input  logic        in_last,
  input  logic        empty,
  input  logic        pop,
  input  logic [15:0] out_word,
  input  logic [3:0]  out_index,
  input  logic        out_last,
  input  logic        cfg_wen,
  input  logic        cfg_addr,
  input  logic [4:0]  cfg_data,
  output int          mismatches,
  output int          awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  import bts_pkg::*;

  dir_t        mode;
  cnt_t        tail_pixels;
  word_t       grp_words [GROUP_SIZE];
  int unsigned grp_fill;
  result_t     awaited_q [$];

  function automatic word_t sign_fold(word_t px);
    word_t neg;
    neg = ~px + 16'd1;
    if (px[15]) begin
      return {neg[14:0], 1'b1};
    end
    return {px[14:0], 1'b0};
  endfunction

  function automatic word_t sign_unfold(logic sgn, logic [14:0] mag);
    if (!sgn) begin
      return {1'b0, mag};
    end
    if (mag == 15'd0) begin
      return 16'h8000;
    end
    return ~{1'b0, mag} + 16'd1;
  endfunction

  task automatic clear_group();
    foreach (grp_words[i]) grp_words[i] = '0;
    grp_fill = 0;
  endtask

  // Turns the stored raw words into the results of one group, read in the
  // direction that is set at the moment the group closes.
  task automatic transpose_group(input logic is_last);
    word_t       folded [GROUP_SIZE];
    result_t     r;
    logic [14:0] mag;
    int          n;
    if (mode == DIR_ENCODE) begin
      for (int p = 0; p < GROUP_SIZE; p++) folded[p] = sign_fold(grp_words[p]);
      for (int k = 0; k < GROUP_SIZE; k++) begin
        for (int p = 0; p < GROUP_SIZE; p++) r.word[p] = folded[p][k];
        r.index = pos_t'(k);
        r.last  = is_last && (k == GROUP_SIZE - 1);
        awaited_q.push_back(r);
      end
    end else begin
      n = GROUP_SIZE;
      if (is_last) begin
        if (tail_pixels == 5'd0) begin
          n = 1;
        end else if (tail_pixels > FULL_GROUP) begin
          n = GROUP_SIZE;
        end else begin
          n = int'(tail_pixels);
        end
      end
      for (int p = 0; p < n; p++) begin
        for (int b = 1; b < GROUP_SIZE; b++) mag[b-1] = grp_words[b][p];
        r.word  = sign_unfold(grp_words[0][p], mag);
        r.index = pos_t'(p);
        r.last  = is_last && (p == n - 1);
        awaited_q.push_back(r);
      end
    end
    clear_group();
  endtask

  task automatic check_result();
    result_t want;
    if (awaited_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual word %h index %0d last %b",
               $time, out_word, out_index, out_last);
      mismatches++;
    end else begin
      want = awaited_q.pop_front();
      if (out_word !== want.word) begin
        $display("%0t: out_word at index %0d, expected %h, actual %h",
                 $time, want.index, want.word, out_word);
        mismatches++;
      end
      if (out_index !== want.index) begin
        $display("%0t: out_index, expected %0d, actual %0d", $time, want.index, out_index);
        mismatches++;
      end
      if (out_last !== want.last) begin
        $display("%0t: out_last at index %0d, expected %b, actual %b",
                 $time, want.index, want.last, out_last);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode        = DIR_ENCODE;
      tail_pixels = FULL_GROUP;
      clear_group();
      awaited_q.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_addr)
          CFG_DIRECTION:    mode = dir_t'(cfg_data[0]);
          CFG_FINAL_PIXELS: tail_pixels = cfg_data;
          default: ;
        endcase
      end
      if (!empty && pop) begin
        check_result();
      end
      if (push && !full) begin
        grp_words[grp_fill] = in_word;
        if (grp_fill < GROUP_SIZE - 1 && !in_last) begin
          grp_fill++;
        end else begin
          transpose_group(in_last);
        end
      end
    end
    awaiting = awaited_q.size();
  end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// Bit-plane transpose testbench
// Drives pixel and plane word streams into the transpose block in both
// directions, with directed corner cases first and random streams after,
// under changing idle patterns on both queues and one long receiver stall.
// The checker beside the block predicts and compares; this module only makes
// stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bts_pkg::*;

  // Cycles to let pass once nothing is expected, so that a group still being
  // written, or a result not yet out after its closing transaction, settles.
  localparam int DRAIN_CYCLES = 20;
  // Length of the receiver hold-off that fills both group buffers.
  localparam int HOLD_CYCLES  = 300;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        push     = 1'b0;
  logic [15:0] in_word  = '0;
  logic        in_last  = 1'b0;
  logic        pop      = 1'b0;
  logic        cfg_wen  = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [4:0]  cfg_data = '0;
  logic        full;
  logic        empty;
  logic [15:0] out_word;
  logic [3:0]  out_index;
  logic        out_last;

  int   mismatches;
  int   awaiting;

  // Idle rates in percent for the sender and the receiver; the stimulus
  // process changes them between phases.
  int   send_idle_pct = 13;
  int   pop_idle_pct  = 60;
  // Each toggle asks the receiver process for one long hold-off.
  logic hold_go       = 1'b0;
  int   items_sent    = 0;
  dir_t stream_dir    = DIR_ENCODE;

  always #1 clk = ~clk;

  bitplane_transpose_sign_fold uut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .in_last   (in_last),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word),
    .out_index (out_index),
    .out_last  (out_last),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  bitplane_checker chk (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_word    (in_word),
    .in_last    (in_last),
    .empty      (empty),
    .pop        (pop),
    .out_word   (out_word),
    .out_index  (out_index),
    .out_last   (out_last),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  // Receiver: pops at random according to the current idle rate. When the
  // stimulus toggles hold_go, it holds pop low for a HOLD_CYCLES hold-off, which
  // it counts itself, so that the result queue and both group buffers fill
  // and the block raises full against the sender.
  initial begin : receiver
    int   hold_left = 0;
    logic hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(0, 99) >= pop_idle_pct);
      end
    end
  end

  // Offers one word and returns at the edge where the transaction completes.
  // Push stays high afterwards, so back-to-back words need only one
  // assignment per time step; an idle gap lowers it first.
  task automatic send_word(input word_t w, input logic is_last);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    push    <= 1'b1;
    in_word <= w;
    in_last <= is_last;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  // Stops offering, waits until every predicted result has been popped, then
  // lets the block settle. Registers are only written after this.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [4:0] data);
    cfg_wen  <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    cfg_wen  <= 1'b0;
    @(posedge clk);
  endtask

  // Random content, biased toward the corner pixels. In decode, zero plane
  // words are frequent so that a set sign with zero magnitude, the most
  // negative pixel, shows up often.
  function automatic word_t pick_word(dir_t d);
    word_t corners [6] = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h8001};
    case ($urandom_range(0, 7))
      0: begin
        return corners[$urandom_range(0, 5)];
      end
      1, 2: begin
        if (d == DIR_DECODE) begin
          return 16'h0000;
        end
        return word_t'($urandom);
      end
      default: begin
        return word_t'($urandom);
      end
    endcase
  endfunction

  // Pixel count of the final decode group, including the out-of-range
  // values 0 and 17..31 that the block must clamp.
  function automatic cnt_t pick_tail();
    case ($urandom_range(0, 5))
      0:       return 5'd0;
      1:       return 5'd1;
      2:       return FULL_GROUP;
      3:       return cnt_t'($urandom_range(17, 31));
      default: return cnt_t'($urandom_range(2, 15));
    endcase
  endfunction

  task automatic send_stream(input int len, input logic ends, input dir_t d);
    for (int i = 0; i < len; i++) begin
      send_word(pick_word(d), ends && (i == len - 1));
    end
  endtask

  // Random streams, each under a fresh setting. Most streams are whole
  // groups followed by a short group closed by in_last; some are a single
  // short group, and a few end without in_last so that the next setting
  // finds a partly filled group.
  task automatic run_phase(input int target);
    int stop_at;
    int len;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      wait_idle();
      stream_dir = dir_t'($urandom_range(0, 1));
      write_reg(CFG_DIRECTION, {4'd0, stream_dir});
      write_reg(CFG_FINAL_PIXELS, pick_tail());
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 16);
      end else begin
        len = 16 * $urandom_range(1, 3) + $urandom_range(0, 15);
      end
      send_stream(len, $urandom_range(0, 7) != 0, stream_dir);
    end
  endtask

  initial begin : stimulus
    word_t corner_pixels [16] = '{
      16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h8001, 16'h5555, 16'hAAAA,
      16'h00FF, 16'hFF00, 16'h4000, 16'hC000, 16'h0002, 16'hFFFE, 16'h3C3C, 16'hC3C3
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Phase one: sender idles rarely, receiver often.
    send_idle_pct = 13;
    pop_idle_pct  = 60;

    // Encode at the reset settings: one full group of corner pixels, the
    // most negative pixel among them, then a short group closed by in_last
    // whose missing pixels are zero.
    foreach (corner_pixels[i]) send_word(corner_pixels[i], 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h1234, 1'b1);

    // Decode a short group with a pixel count of zero, which counts as one:
    // all signs set and all magnitudes zero give the most negative pixel.
    wait_idle();
    write_reg(CFG_DIRECTION, {4'd0, DIR_DECODE});
    write_reg(CFG_FINAL_PIXELS, 5'd0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b1);

    // Direction change mid-group: one plane word arrives while decoding, the
    // direction flips to encode, and the stored word is read as a pixel.
    wait_idle();
    write_reg(CFG_FINAL_PIXELS, 5'd31);
    send_word(16'hA5C3, 1'b0);
    wait_idle();
    write_reg(CFG_DIRECTION, {4'd0, DIR_ENCODE});
    send_word(16'h8000, 1'b1);

    // Decode with a pixel count above sixteen, clamped to a full group; the
    // alternating sign plane gives zero and the most negative pixel in turn.
    wait_idle();
    write_reg(CFG_DIRECTION, {4'd0, DIR_DECODE});
    send_word(16'h5A5A, 1'b1);

    run_phase(60);

    // Phase two: the idle rates swap.
    send_idle_pct = 60;
    pop_idle_pct  = 13;
    run_phase(60);

    // Phase three: nobody idles. It opens with a long receiver hold-off
    // while a long encode stream keeps coming, so the block stalls its input.
    send_idle_pct = 0;
    pop_idle_pct  = 0;
    wait_idle();
    stream_dir = DIR_ENCODE;
    write_reg(CFG_DIRECTION, {4'd0, stream_dir});
    write_reg(CFG_FINAL_PIXELS, FULL_GROUP);
    hold_go <= ~hold_go;
    send_stream(72, 1'b1, stream_dir);
    run_phase(40);

    // Close any group left open by a stream that ended without in_last.
    send_word(pick_word(stream_dir), 1'b1);
    wait_idle();

    if (mismatches == 0 && awaiting == 0 && empty) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
